FILE: hdl/trrq_pkg.sv
`timescale 1ns / 1ps

package trrq_pkg;

    localparam int DEPTH       = 32;
    localparam int MAX_PAYLOAD = 4096;
    localparam int IDX_W       = $clog2(DEPTH);
    localparam int CNT_W       = $clog2(DEPTH + 1);
    localparam int HANDLE_W    = 16;
    localparam int REF_W       = 32;
    localparam int SIZE_W      = 13;
    localparam int DELAY_W     = 32;
    localparam int TIME_W      = 48;

    typedef enum logic [1:0] {
        REQ_PUSH    = 2'd0,
        REQ_PROCESS = 2'd1,
        REQ_CLEAR   = 2'd2
    } req_t;

    typedef enum logic [2:0] {
        STAT_QUEUED    = 3'd0,
        STAT_FULL      = 3'd1,
        STAT_NULL      = 3'd2,
        STAT_OVERSIZE  = 3'd3,
        STAT_RELEASED  = 3'd4,
        STAT_NONE_DUE  = 3'd5,
        STAT_CLEARED   = 3'd6
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PUSH,
        S_CLEAR,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_COMPACT,
        S_PLACE,
        S_FINISH,
        S_EMIT
    } state_t;

    typedef struct packed {
        logic [TIME_W-1:0]   due;
        logic [SIZE_W-1:0]   size;
        logic [REF_W-1:0]    payload_ref;
        logic [HANDLE_W-1:0] handle;
    } slot_t;

    typedef struct packed {
        status_t             status;
        logic [HANDLE_W-1:0] handle;
        logic [REF_W-1:0]    payload_ref;
        logic [SIZE_W-1:0]   size;
        logic [CNT_W-1:0]    pending;
        logic                last;
    } res_t;

    function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] i);
        logic [IDX_W-1:0] r;
        if (i == IDX_W'(DEPTH - 1))
        begin
            r = '0;
        end
        else
        begin
            r = i + IDX_W'(1);
        end
        return r;
    endfunction

endpackage

FILE: hdl/trrq_ram.sv
`timescale 1ns / 1ps

module trrq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: hdl/timed_release_ring_queue.sv
`timescale 1ns / 1ps
// A push or a clear gives a single result, and a new request is taken only once it is sent
// on. A process request skips each scanned slot that is empty and reads and checks each
// occupied one; the head passes over slots freed by a release, and each release is held
// back until the next one or the end of the scan, whose result is marked as the last.
// Ready is low until the last result is registered, and a stalled output holds the block
// waiting to emit. Reset clears the valid bits, head, tail and count, not the slot memory.
module timed_release_ring_queue
    import trrq_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // callback_handle[15:0], payload_ref[47:16], payload_size[60:48],
    // release_delay[92:61], now_ms[140:93], zero[143:141]
    input  logic [143:0] s_axis_tdata,
    // req_type[1:0]
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // out_handle[15:0], out_payload_ref[47:16], out_payload_size[60:48],
    // pending_count[66:61], zero[71:67]
    output logic [71:0]  m_axis_tdata,
    // status[2:0]
    output logic [2:0]   m_axis_tuser,
    output logic         m_axis_tlast
);

    state_t state_reg, state_next;

    logic [HANDLE_W-1:0] handle_reg, handle_next;
    logic [REF_W-1:0]    ref_reg, ref_next;
    logic [SIZE_W-1:0]   size_reg, size_next;
    logic [DELAY_W-1:0]  delay_reg, delay_next;
    logic [TIME_W-1:0]   now_reg, now_next;

    logic [IDX_W-1:0]    head_reg, head_next;
    logic [IDX_W-1:0]    tail_reg, tail_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [DEPTH-1:0]    valid_reg, valid_next;

    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [CNT_W-1:0]    k_reg, k_next;
    logic [CNT_W-1:0]    to_check_reg, to_check_next;

    slot_t               cand_reg, cand_next;
    res_t                held_reg, held_next;
    logic                held_vld_reg, held_vld_next;
    res_t                res_reg, res_next;
    logic                ret_scan_reg, ret_scan_next;
    res_t                out_reg, out_next;
    logic                out_vld_reg, out_vld_next;

    logic                ram_we;
    slot_t               ram_wdata;
    slot_t               ram_rdata;

    logic                out_free;
    logic                scan_done;
    logic                is_due;
    logic                head_empty;
    logic [TIME_W:0]     due_sum;
    logic [TIME_W-1:0]   due_val;
    status_t             push_status;

    trrq_ram #(
        .WIDTH ($bits(slot_t)),
        .DEPTH (DEPTH)
    ) u_slots (
        .clk   (clk),
        .we    (ram_we),
        .waddr (tail_reg),
        .wdata (ram_wdata),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    assign out_free   = !out_vld_reg || m_axis_tready;
    assign scan_done  = (k_reg == to_check_reg);
    assign is_due     = (ram_rdata.due == '0) || (ram_rdata.due <= now_reg);
    assign head_empty = (count_reg != '0) && !valid_reg[head_reg];

    assign due_sum = {1'b0, now_reg} + {{(TIME_W + 1 - DELAY_W){1'b0}}, delay_reg};

    always_comb
    begin
        if (delay_reg == '0)
        begin
            due_val = '0;
        end
        else if (due_sum[TIME_W])
        begin
            due_val = '1;
        end
        else
        begin
            due_val = due_sum[TIME_W-1:0];
        end
    end

    always_comb
    begin
        if (handle_reg == '0)
        begin
            push_status = STAT_NULL;
        end
        else if (size_reg > SIZE_W'(MAX_PAYLOAD))
        begin
            push_status = STAT_OVERSIZE;
        end
        else if (count_reg >= CNT_W'(DEPTH))
        begin
            push_status = STAT_FULL;
        end
        else
        begin
            push_status = STAT_QUEUED;
        end
    end

    assign ram_we    = (state_reg == S_PUSH) && (push_status == STAT_QUEUED);
    assign ram_wdata = '{due: due_val, size: size_reg, payload_ref: ref_reg,
                         handle: handle_reg};

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    unique case (req_t'(s_axis_tuser))
                        REQ_PUSH:    state_next = S_PUSH;
                        REQ_PROCESS: state_next = S_SCAN_RD;
                        REQ_CLEAR:   state_next = S_CLEAR;
                        default:     state_next = S_IDLE;
                    endcase
                end
            end
            S_PUSH:  state_next = S_EMIT;
            S_CLEAR: state_next = S_EMIT;
            S_SCAN_RD:
            begin
                if (scan_done)
                begin
                    state_next = S_FINISH;
                end
                else if (valid_reg[idx_reg])
                begin
                    state_next = S_SCAN_CHK;
                end
            end
            S_SCAN_CHK: state_next = is_due ? S_COMPACT : S_SCAN_RD;
            S_COMPACT:
            begin
                if (!head_empty)
                begin
                    state_next = S_PLACE;
                end
            end
            S_PLACE:  state_next = held_vld_reg ? S_EMIT : S_SCAN_RD;
            S_FINISH: state_next = S_EMIT;
            S_EMIT:
            begin
                if (out_free)
                begin
                    state_next = ret_scan_reg ? S_SCAN_RD : S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        handle_next   = handle_reg;
        ref_next      = ref_reg;
        size_next     = size_reg;
        delay_next    = delay_reg;
        now_next      = now_reg;
        head_next     = head_reg;
        tail_next     = tail_reg;
        count_next    = count_reg;
        valid_next    = valid_reg;
        idx_next      = idx_reg;
        k_next        = k_reg;
        to_check_next = to_check_reg;
        cand_next     = cand_reg;
        held_next     = held_reg;
        held_vld_next = held_vld_reg;
        res_next      = res_reg;
        ret_scan_next = ret_scan_reg;
        out_next      = out_reg;
        out_vld_next  = out_vld_reg && !m_axis_tready;

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    handle_next   = s_axis_tdata[15:0];
                    ref_next      = s_axis_tdata[47:16];
                    size_next     = s_axis_tdata[60:48];
                    delay_next    = s_axis_tdata[92:61];
                    now_next      = s_axis_tdata[140:93];
                    k_next        = '0;
                    to_check_next = count_reg;
                    idx_next      = head_reg;
                    held_vld_next = 1'b0;
                end
            end
            S_PUSH:
            begin
                if (push_status == STAT_QUEUED)
                begin
                    valid_next[tail_reg] = 1'b1;
                    tail_next            = ring_next(tail_reg);
                    count_next           = count_reg + CNT_W'(1);
                end
                res_next = '{status: push_status, handle: '0, payload_ref: '0, size: '0,
                             pending: count_next, last: 1'b1};
                ret_scan_next = 1'b0;
            end
            S_CLEAR:
            begin
                valid_next    = '0;
                head_next     = '0;
                tail_next     = '0;
                count_next    = '0;
                res_next      = '{status: STAT_CLEARED, handle: '0, payload_ref: '0,
                                  size: '0, pending: '0, last: 1'b1};
                ret_scan_next = 1'b0;
            end
            S_SCAN_RD:
            begin
                if (!scan_done && !valid_reg[idx_reg])
                begin
                    k_next   = k_reg + CNT_W'(1);
                    idx_next = ring_next(idx_reg);
                end
            end
            S_SCAN_CHK:
            begin
                k_next   = k_reg + CNT_W'(1);
                idx_next = ring_next(idx_reg);
                if (is_due)
                begin
                    valid_next[idx_reg] = 1'b0;
                    cand_next           = ram_rdata;
                end
            end
            S_COMPACT:
            begin
                if (head_empty)
                begin
                    head_next  = ring_next(head_reg);
                    count_next = count_reg - CNT_W'(1);
                end
            end
            S_PLACE:
            begin
                held_next = '{status: STAT_RELEASED, handle: cand_reg.handle,
                              payload_ref: cand_reg.payload_ref, size: cand_reg.size,
                              pending: count_reg, last: 1'b0};
                held_vld_next = 1'b1;
                if (held_vld_reg)
                begin
                    res_next      = held_reg;
                    ret_scan_next = 1'b1;
                end
            end
            S_FINISH:
            begin
                if (held_vld_reg)
                begin
                    res_next      = held_reg;
                    res_next.last = 1'b1;
                end
                else
                begin
                    res_next = '{status: STAT_NONE_DUE, handle: '0, payload_ref: '0,
                                 size: '0, pending: count_reg, last: 1'b1};
                end
                ret_scan_next = 1'b0;
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_next     = res_reg;
                    out_vld_next = 1'b1;
                end
            end
            default:
            begin
                ret_scan_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            head_reg     <= '0;
            tail_reg     <= '0;
            count_reg    <= '0;
            valid_reg    <= '0;
            idx_reg      <= '0;
            k_reg        <= '0;
            to_check_reg <= '0;
            held_vld_reg <= 1'b0;
            ret_scan_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            count_reg    <= count_next;
            valid_reg    <= valid_next;
            idx_reg      <= idx_next;
            k_reg        <= k_next;
            to_check_reg <= to_check_next;
            held_vld_reg <= held_vld_next;
            ret_scan_reg <= ret_scan_next;
            out_vld_reg  <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        handle_reg <= handle_next;
        ref_reg    <= ref_next;
        size_reg   <= size_next;
        delay_reg  <= delay_next;
        now_reg    <= now_next;
        cand_reg   <= cand_next;
        held_reg   <= held_next;
        res_reg    <= res_next;
        out_reg    <= out_next;
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = {5'b0, out_reg.pending, out_reg.size, out_reg.payload_ref,
                            out_reg.handle};
    assign m_axis_tuser  = out_reg.status;
    assign m_axis_tlast  = out_reg.last;

endmodule
